### src/transfer_ring_trb_producer_assert.svh
// Assertion macros for the transfer ring descriptor producer.
// Used by the port checker; no other dependencies.
`ifndef TRANSFER_RING_TRB_PRODUCER_ASSERT_SVH
`define TRANSFER_RING_TRB_PRODUCER_ASSERT_SVH

// Clocked assertion, disabled while reset is high.
`define TRP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked only while a result beat is offered.
`define TRP_ASSERT_BEAT(label, clk, rst, vld, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) vld |-> prop) else $error(msg);

`endif

### src/trp_pkg.sv
// Shared constants, codes and controller/datapath structs of the
// transfer ring descriptor producer. No dependencies.
package trp_pkg;

   localparam int DEF_RING_SIZE  = 256;
   localparam int DEF_PAGE_BYTES = 4096;
   localparam int DEF_MAX_SPLIT  = 32;

   // request opcodes
   localparam logic [2:0] OP_SETUP  = 3'd0;
   localparam logic [2:0] OP_DATA   = 3'd1;
   localparam logic [2:0] OP_STATUS = 3'd2;
   localparam logic [2:0] OP_EVENT  = 3'd3;
   localparam logic [2:0] OP_PAGED  = 3'd4;

   // descriptor type codes, word3 bits 15:10
   localparam logic [5:0] TRB_NORMAL = 6'd1;
   localparam logic [5:0] TRB_SETUP  = 6'd2;
   localparam logic [5:0] TRB_DATA   = 6'd3;
   localparam logic [5:0] TRB_STATUS = 6'd4;
   localparam logic [5:0] TRB_LINK   = 6'd6;
   localparam logic [5:0] TRB_EVENT  = 6'd7;

   // config register indexes
   localparam logic CSR_RING_BASE = 1'b0;
   localparam logic CSR_MPS       = 1'b1;

   localparam logic [10:0] MPS_RESET = 11'd64;
   localparam logic [31:0] SETUP_LEN = 32'd8;
   localparam int          CW        = 6;   // descriptor count width
   localparam int          DIV_BITS  = 17;  // divider dividend width

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  request_type;
      logic [7:0]  request_code;
      logic [15:0] setup_value;
      logic [15:0] setup_index;
      logic [15:0] byte_length;
      logic [31:0] buffer_addr;
      logic        direction;
      logic [1:0]  transfer_type;
      logic        want_interrupt;
   } req_type;

   typedef struct packed {
      logic load_req;
      logic div_start;
      logic div_sel_rest;
      logic init_iter;
      logic load_piece;
      logic emit_link;
      logic emit_desc;
      logic emit_reject;
   } cmd_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic       len_zero;
      logic       div_busy;
      logic       count_over;
      logic       page_over;
      logic       at_ring_end;
      logic       final_desc;
      logic       out_free;
   } stat_type;

endpackage

### src/trp_ctrl.sv
// Sequencer of the transfer ring descriptor producer.
// Depends on trp_pkg; drives commands to trp_datapath.
module trp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  trp_pkg::stat_type stat,
   output trp_pkg::cmd_type  cmd
);
   import trp_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_DIVCNT = 3'd2;
   localparam logic [2:0] S_PIECE  = 3'd3;
   localparam logic [2:0] S_PSTART = 3'd4;
   localparam logic [2:0] S_DIVREM = 3'd5;
   localparam logic [2:0] S_EMIT   = 3'd6;
   localparam logic [2:0] S_REJECT = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.opcode)
               OP_SETUP, OP_STATUS, OP_EVENT: state_in = S_EMIT;
               OP_DATA: begin
                  if (stat.len_zero) begin
                     state_in = S_IDLE;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIVCNT;
                  end
               end
               OP_PAGED: begin
                  if (stat.len_zero) begin
                     state_in = S_IDLE;
                  end else if (stat.page_over) begin
                     state_in = S_REJECT;
                  end else begin
                     cmd.init_iter = 1'b1;
                     state_in      = S_PIECE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_DIVCNT: begin
            if (!stat.div_busy) begin
               if (stat.count_over) begin
                  state_in = S_REJECT;
               end else begin
                  cmd.init_iter = 1'b1;
                  state_in      = S_EMIT;
               end
            end
         end
         S_PIECE: begin
            cmd.load_piece = 1'b1;
            state_in       = S_PSTART;
         end
         S_PSTART: begin
            cmd.div_start    = 1'b1;
            cmd.div_sel_rest = 1'b1;
            state_in         = S_DIVREM;
         end
         S_DIVREM: begin
            if (!stat.div_busy) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               if (stat.at_ring_end) begin
                  cmd.emit_link = 1'b1;
               end else begin
                  cmd.emit_desc = 1'b1;
                  if (stat.final_desc)               state_in = S_IDLE;
                  else if (stat.opcode == OP_PAGED)  state_in = S_PIECE;
               end
            end
         end
         S_REJECT: begin
            if (stat.out_free) begin
               cmd.emit_reject = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

### src/trp_datapath.sv
// Datapath of the transfer ring descriptor producer: request and config
// registers, ring index, serial divider, descriptor build, result register.
// Depends on trp_pkg; commanded by trp_ctrl.
module trp_datapath #(
   parameter int RING_SIZE  = trp_pkg::DEF_RING_SIZE,
   parameter int PAGE_BYTES = trp_pkg::DEF_PAGE_BYTES,
   parameter int MAX_SPLIT  = trp_pkg::DEF_MAX_SPLIT
) (
   input  logic              clock,
   input  logic              reset,
   input  trp_pkg::req_type  req,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata,
   input  trp_pkg::cmd_type  cmd,
   output trp_pkg::stat_type stat,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [135:0]      rsp_tdata,
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);
   import trp_pkg::*;

   localparam int IW = $clog2(RING_SIZE);
   localparam int PL = $clog2(PAGE_BYTES);
   localparam int PW = PL + 1;
   localparam logic [IW-1:0] LAST_SLOT = IW'(RING_SIZE - 1);

   req_type         req_ff;
   logic [31:0]     base_ff;
   logic [10:0]     mps_ff;
   logic [IW-1:0]   idx_ff;
   logic            cyc_ff;
   logic [CW-1:0]   count_ff, k_ff;
   logic [15:0]     rest_ff;
   logic [31:0]     addr_ff;
   logic [15:0]     piece_ff;
   logic [DIV_BITS-1:0] dvd_ff;
   logic [11:0]     rem_ff;
   logic [4:0]      dcnt_ff;
   logic            busy_ff;
   logic            vld_ff;
   logic [135:0]    data_ff;
   logic [1:0]      user_ff;
   logic            last_ff;

   logic [10:0]     mps;
   assign mps = (mps_ff == 11'd0) ? 11'd1 : mps_ff;

   // page split of the current address
   logic [PW-1:0]   pg_left;
   logic [17:0]     first, pg_tail, pg_count;
   assign pg_left  = PW'(PAGE_BYTES) - {1'b0, addr_ff[PL-1:0]};
   assign first    = (18'(pg_left) > 18'(req_ff.byte_length))
                     ? 18'(req_ff.byte_length) : 18'(pg_left);
   assign pg_tail  = 18'(req_ff.byte_length) - first + 18'(PAGE_BYTES - 1);
   assign pg_count = 18'd1 + (pg_tail >> PL);

   logic [15:0]     pg_piece;
   assign pg_piece = (18'(rest_ff) < 18'(pg_left)) ? rest_ff : 16'(pg_left);

   // data stage piece and remaining count
   logic [15:0]     dt_piece;
   logic [CW-1:0]   dt_remp;
   assign dt_piece = (rest_ff < 16'(mps)) ? rest_ff : 16'(mps);
   assign dt_remp  = count_ff - CW'(1) - k_ff;

   // divider quotient, saturated for the size field
   logic [4:0]      q_sat;
   assign q_sat = (dvd_ff > DIV_BITS'(31)) ? 5'd31 : dvd_ff[4:0];

   // serial restoring divider step
   logic [11:0]     rem_sh, rem_sub;
   logic            rem_ge;
   assign rem_sh  = {rem_ff[10:0], dvd_ff[DIV_BITS-1]};
   assign rem_ge  = rem_sh >= {1'b0, mps};
   assign rem_sub = rem_sh - {1'b0, mps};

   // build the descriptor for the current step
   logic [31:0] w0, w1, w2, w3;
   logic        fin;
   always_comb begin
      w0  = '0;
      w1  = '0;
      w2  = '0;
      w3  = '0;
      fin = 1'b1;
      case (req_ff.opcode)
         OP_SETUP: begin
            w0 = {req_ff.setup_value, req_ff.request_code, req_ff.request_type};
            w1 = {req_ff.byte_length, req_ff.setup_index};
            w2 = SETUP_LEN;
            w3 = {14'd0, req_ff.transfer_type, TRB_SETUP, 10'b0001000000};
         end
         OP_DATA: begin
            fin = (dt_remp == '0);
            w0  = addr_ff;
            w2  = {10'd0, dt_remp[4:0], 1'b0, dt_piece};
            w3  = {15'd0, (k_ff == '0) & req_ff.direction,
                   (k_ff == '0) ? TRB_DATA : TRB_NORMAL, 5'd0, !fin, 4'd0};
         end
         OP_STATUS: begin
            w3 = {15'd0, req_ff.direction, TRB_STATUS, 10'b0000100000};
         end
         OP_EVENT: begin
            w0 = addr_ff;
            w3 = {16'd0, TRB_EVENT, 4'd0, req_ff.want_interrupt, 5'd0};
         end
         OP_PAGED: begin
            fin = (dvd_ff == '0);
            w0  = addr_ff;
            w2  = {10'd0, q_sat, 1'b0, piece_ff};
            w3  = {15'd0, req_ff.direction, TRB_DATA, 4'd0, fin, !fin, 4'd0};
         end
         default: fin = 1'b1;
      endcase
   end

   logic [31:0] idx32;
   logic [31:0] last32;
   assign idx32  = 32'(idx_ff);
   assign last32 = 32'(LAST_SLOT);

   // status to the sequencer
   assign stat.opcode      = req_ff.opcode;
   assign stat.len_zero    = (req_ff.byte_length == 16'd0);
   assign stat.div_busy    = busy_ff;
   assign stat.count_over  = dvd_ff > DIV_BITS'(MAX_SPLIT);
   assign stat.page_over   = pg_count > 18'(MAX_SPLIT);
   assign stat.at_ring_end = (idx_ff == LAST_SLOT);
   assign stat.final_desc  = fin;
   assign stat.out_free    = !vld_ff || rsp_tready;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         mps_ff  <= MPS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RING_BASE: base_ff <= csr_wdata;
            CSR_MPS:       mps_ff  <= csr_wdata[10:0];
            default:       ;
         endcase
      end
   end

   // ring index and producer cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         cyc_ff <= 1'b1;
      end else if (cmd.emit_link) begin
         idx_ff <= '0;
         cyc_ff <= !cyc_ff;
      end else if (cmd.emit_desc) begin
         idx_ff <= idx_ff + IW'(1);
      end
   end

   // request and iteration registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff  <= req;
         addr_ff <= req.buffer_addr;
      end
      if (cmd.init_iter) begin
         count_ff <= dvd_ff[CW-1:0];
         k_ff     <= '0;
         rest_ff  <= req_ff.byte_length;
      end
      if (cmd.load_piece) begin
         piece_ff <= pg_piece;
         rest_ff  <= rest_ff - pg_piece;
      end
      if (cmd.emit_desc) begin
         if (req_ff.opcode == OP_PAGED) begin
            addr_ff <= addr_ff + 32'(piece_ff);
         end else begin
            addr_ff <= addr_ff + 32'(mps);
            rest_ff <= rest_ff - dt_piece;
            k_ff    <= k_ff + CW'(1);
         end
      end
   end

   // divider: one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && dcnt_ff == 5'd1) begin
         busy_ff <= 1'b0;
      end
      if (cmd.div_start) begin
         dvd_ff  <= (cmd.div_sel_rest ? DIV_BITS'(rest_ff) : DIV_BITS'(req_ff.byte_length))
                    + DIV_BITS'(mps) - DIV_BITS'(1);
         rem_ff  <= '0;
         dcnt_ff <= 5'(DIV_BITS);
      end else if (busy_ff) begin
         rem_ff  <= rem_ge ? rem_sub : rem_sh;
         dvd_ff  <= {dvd_ff[DIV_BITS-2:0], rem_ge};
         dcnt_ff <= dcnt_ff - 5'd1;
      end
   end

   // result register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (cmd.emit_link || cmd.emit_desc || cmd.emit_reject) begin
         vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         vld_ff <= 1'b0;
      end
      if (cmd.emit_link) begin
         data_ff <= {16'd0, TRB_LINK, 9'b000000001, cyc_ff, 64'd0,
                     base_ff[31:4], 4'd0, last32[7:0]};
         user_ff <= 2'b01;
         last_ff <= 1'b0;
      end else if (cmd.emit_desc) begin
         data_ff <= {w3 | {31'd0, cyc_ff}, w2, w1, w0, idx32[7:0]};
         user_ff <= 2'b00;
         last_ff <= fin;
      end else if (cmd.emit_reject) begin
         data_ff <= {128'd0, idx32[7:0]};
         user_ff <= 2'b10;
         last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

### src/transfer_ring_trb_producer.sv
// Transfer ring descriptor producer: one request in, a run of ring
// descriptor beats out. Setup, status and event requests are decoded, then
// emit their beat; a data stage runs a 17-step serial divider, then one beat
// a cycle while the output takes them; paged data reruns the divider per piece.
// One request at a time; a ring wrap adds one link beat. Synchronous reset:
// index 0, cycle bit 1, ring base 0, max packet 64. PAGE_BYTES: power of two.
module transfer_ring_trb_producer #(
   parameter int RING_SIZE  = trp_pkg::DEF_RING_SIZE,
   parameter int PAGE_BYTES = trp_pkg::DEF_PAGE_BYTES,
   parameter int MAX_SPLIT  = trp_pkg::DEF_MAX_SPLIT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // request_type, request_code, setup_value, setup_index, byte_length,
   // buffer_addr, direction, transfer_type, want_interrupt, zero fill
   input  logic [103:0] req_tdata,
   // opcode
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // slot_index, word0, word1, word2, word3
   output logic [135:0] rsp_tdata,
   // is_link, status
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);
   import trp_pkg::*;

   req_type  req;
   cmd_type  cmd;
   stat_type stat;

   // unpack the request beat
   assign req.opcode         = req_tuser;
   assign req.request_type   = req_tdata[7:0];
   assign req.request_code   = req_tdata[15:8];
   assign req.setup_value    = req_tdata[31:16];
   assign req.setup_index    = req_tdata[47:32];
   assign req.byte_length    = req_tdata[63:48];
   assign req.buffer_addr    = req_tdata[95:64];
   assign req.direction      = req_tdata[96];
   assign req.transfer_type  = req_tdata[98:97];
   assign req.want_interrupt = req_tdata[99];

   trp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   trp_datapath #(
      .RING_SIZE  (RING_SIZE),
      .PAGE_BYTES (PAGE_BYTES),
      .MAX_SPLIT  (MAX_SPLIT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### src/trp_checker.sv
// Port checker for the transfer ring descriptor producer, bound to the top.
// Depends on transfer_ring_trb_producer_assert.svh.
`include "transfer_ring_trb_producer_assert.svh"
module trp_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [103:0] req_tdata,
   input logic [2:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast,
   input logic         csr_we,
   input logic         csr_index,
   input logic [31:0]  csr_wdata
);
   // a stalled result beat holds
   `TRP_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp beat dropped or changed")
   // one request at a time
   `TRP_ASSERT(a_one_req, clock, reset, req_tvalid && req_tready |=> !req_tready, "request taken while busy")
   // a link beat never closes a request and is never an error
   `TRP_ASSERT_BEAT(a_link_mid, clock, reset, rsp_tvalid && rsp_tuser[0], !rsp_tlast && !rsp_tuser[1], "bad link beat")
   // a reject is a single closing beat with empty words
   `TRP_ASSERT_BEAT(a_rej_last, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tlast && rsp_tdata[135:8] == 128'd0, "bad reject beat")
endmodule

bind transfer_ring_trb_producer trp_checker u_trp_checker (.*);

### verif/transfer_ring_trb_producer_test.sv
// Self-checking testbench for the transfer ring descriptor producer.
// Depends on trp_pkg and transfer_ring_trb_producer; predicts every descriptor beat.
module transfer_ring_trb_producer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import trp_pkg::*;

   localparam int RING_LAST  = DEF_RING_SIZE - 1;
   localparam int PAGE       = DEF_PAGE_BYTES;
   localparam int CYCLE_CAP  = 600000;
   localparam logic [31:0] CHAIN_F  = 32'h10;
   localparam logic [31:0] IOC_F    = 32'h20;
   localparam logic [31:0] IDT_F    = 32'h40;
   localparam logic [31:0] TOGGLE_F = 32'h2;

   typedef struct packed {
      logic [7:0]  slot;
      logic [31:0] w0, w1, w2, w3;
      logic        lnk, st, lst;
   } trb_beat_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [135:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 0;
   logic         csr_index = CSR_RING_BASE;
   logic [31:0]  csr_wdata = '0;

   transfer_ring_trb_producer DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // ring model state and queues
   int unsigned  enq_idx = 0;
   logic         prod_cycle = 1;
   logic [31:0]  ring_base = 0;
   logic [10:0]  max_packet = MPS_RESET;
   req_type      pending_reqs[$];
   trb_beat_type expected_trbs[$];
   req_type      cur_req;
   int           accepted = 0;
   int           cycles = 0;
   int           errors = 0;
   logic         calm;
   int           hold_left = 0;
   logic         hold_done = 0;

   assign calm = (cycles > 3000 && cycles < 8000);

   // Claim the next slot, writing the link descriptor first at the ring end
   task automatic claim_slot(output logic [7:0] slot);
      trb_beat_type b;
      if (enq_idx >= RING_LAST) begin
         b.slot = RING_LAST[7:0];
         b.w0 = ring_base & ~32'hF;
         b.w1 = '0;
         b.w2 = '0;
         b.w3 = (32'(TRB_LINK) << 10) | TOGGLE_F | 32'(prod_cycle);
         b.lnk = 1'b1; b.st = 1'b0; b.lst = 1'b0;
         expected_trbs.push_back(b);
         enq_idx = 0;
         prod_cycle = ~prod_cycle;
      end
      slot = enq_idx[7:0];
      enq_idx++;
   endtask

   task automatic push_trb(logic [31:0] w0, w1, w2, w3, logic lst);
      trb_beat_type b;
      claim_slot(b.slot);
      b.w0 = w0; b.w1 = w1; b.w2 = w2; b.w3 = w3 | 32'(prod_cycle);
      b.lnk = 1'b0; b.st = 1'b0; b.lst = lst;
      expected_trbs.push_back(b);
   endtask

   task automatic push_reject();
      trb_beat_type b;
      b = '0;
      b.slot = enq_idx[7:0];
      b.st = 1'b1;
      b.lst = 1'b1;
      expected_trbs.push_back(b);
   endtask

   function automatic logic [31:0] td_size(longint unsigned v);
      return (v > 31) ? 32'd31 : 32'(v);
   endfunction

   // Work out the descriptor beats one request produces
   task automatic predict_trbs(req_type r);
      longint unsigned mps, len, cnt, rest, piece, remp, first;
      logic [31:0] addr, d3dir, ty;
      mps = (max_packet == 0) ? 64'd1 : 64'(max_packet);
      len = 64'(r.byte_length);
      addr = r.buffer_addr;
      case (r.opcode)
         OP_SETUP:
            push_trb({r.setup_value, r.request_code, r.request_type},
                     {r.byte_length, r.setup_index}, SETUP_LEN,
                     (32'(r.transfer_type) << 16) | IDT_F | (32'(TRB_SETUP) << 10), 1'b1);
         OP_DATA: if (len != 0) begin
            cnt = (len + mps - 1) / mps;
            if (cnt > DEF_MAX_SPLIT) push_reject();
            else begin
               rest = len;
               d3dir = 32'(r.direction);
               ty = 32'(TRB_DATA);
               for (longint unsigned k = 0; k < cnt; k++) begin
                  remp = cnt - 1 - k;
                  piece = (rest < mps) ? rest : mps;
                  push_trb(addr, '0, (td_size(remp) << 17) | 32'(piece),
                           (d3dir << 16) | ((remp != 0) ? CHAIN_F : '0) | (ty << 10),
                           k + 1 == cnt);
                  addr += 32'(mps);
                  rest -= piece;
                  ty = 32'(TRB_NORMAL);
                  d3dir = '0;
               end
            end
         end
         OP_STATUS:
            push_trb('0, '0, '0,
                     (32'(r.direction) << 16) | IOC_F | (32'(TRB_STATUS) << 10), 1'b1);
         OP_EVENT:
            push_trb(addr, '0, '0,
                     (r.want_interrupt ? IOC_F : '0) | (32'(TRB_EVENT) << 10), 1'b1);
         OP_PAGED: if (len != 0) begin
            first = 64'(PAGE) - 64'(addr % PAGE);
            if (first > len) first = len;
            cnt = 1 + (len - first + PAGE - 1) / PAGE;
            if (cnt > DEF_MAX_SPLIT) push_reject();
            else begin
               rest = len;
               while (rest > 0) begin
                  piece = 64'(PAGE) - 64'(addr % PAGE);
                  if (rest < piece) piece = rest;
                  rest -= piece;
                  remp = (rest + mps - 1) / mps;
                  push_trb(addr, '0, (td_size(remp) << 17) | 32'(piece),
                           (32'(r.direction) << 16) | ((remp == 0) ? IOC_F : CHAIN_F)
                           | (32'(TRB_DATA) << 10), remp == 0);
                  addr += 32'(piece);
               end
            end
         end
         default: ;
      endcase
   endtask

   // Drive request beats from the pending queue; predict on acceptance
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_trbs(cur_req);
            accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
               cur_req = pending_reqs.pop_front();
               req_tvalid <= 1;
               req_tuser <= cur_req.opcode;
               req_tdata <= {4'b0, cur_req.want_interrupt, cur_req.transfer_type,
                             cur_req.direction, cur_req.buffer_addr, cur_req.byte_length,
                             cur_req.setup_index, cur_req.setup_value,
                             cur_req.request_code, cur_req.request_type};
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // Result ready: random stalls, one long hold-off to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 0;
      end else if (!hold_done && accepted >= 30) begin
         hold_done <= 1;
         hold_left <= 400;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 28);
      end
   end

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: mismatch %s expected %h actual %h", $realtime, name, exp_v, act_v);
         errors++;
      end
   endfunction

   // Compare each result beat with the oldest expected descriptor
   always @(posedge clock) begin
      trb_beat_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_trbs.size() == 0) begin
            $display("%0t: unexpected beat expected none actual %h", $realtime, rsp_tdata);
            errors++;
         end else begin
            e = expected_trbs.pop_front();
            check_field("slot_index", 32'(e.slot), 32'(rsp_tdata[7:0]));
            check_field("word0", e.w0, rsp_tdata[39:8]);
            check_field("word1", e.w1, rsp_tdata[71:40]);
            check_field("word2", e.w2, rsp_tdata[103:72]);
            check_field("word3", e.w3, rsp_tdata[135:104]);
            check_field("is_link", 32'(e.lnk), 32'(rsp_tuser[0]));
            check_field("status", 32'(e.st), 32'(rsp_tuser[1]));
            check_field("last", 32'(e.lst), 32'(rsp_tlast));
         end
      end
   end

   // Abort on a hang
   always @(posedge clock) begin
      if (cycles > CYCLE_CAP) begin
         $display("transfer_ring_trb_producer_test: done, errors");
         $finish;
      end
   end

   function automatic req_type make_req(logic [2:0] op, logic [15:0] len, logic [31:0] addr);
      req_type r;
      r.opcode = op;
      r.request_type = 8'($urandom);
      r.request_code = 8'($urandom);
      r.setup_value = 16'($urandom);
      r.setup_index = 16'($urandom);
      r.byte_length = len;
      r.buffer_addr = addr;
      r.direction = 1'($urandom);
      r.transfer_type = 2'($urandom);
      r.want_interrupt = 1'($urandom);
      return r;
   endfunction

   function automatic req_type random_req();
      int pick;
      logic [2:0] op;
      logic [15:0] len;
      int mps;
      pick = $urandom_range(99);
      mps = (max_packet == 0) ? 1 : int'(max_packet);
      if (pick < 4) op = 3'($urandom_range(7, 5));
      else op = 3'($urandom_range(4));
      pick = $urandom_range(99);
      if (pick < 5) len = '0;
      else if (pick < 20) len = 16'($urandom);
      else if (op == OP_PAGED) len = 16'($urandom_range(3 * PAGE));
      else len = 16'($urandom_range((mps * 33 > 65535) ? 65535 : mps * 33, 1));
      return make_req(op, len, $urandom);
   endfunction

   // Sample at the falling edge so all beat updates of the cycle have settled
   task automatic wait_drained();
      @(negedge clock);
      while (!(pending_reqs.size() == 0 && !req_tvalid && expected_trbs.size() == 0))
         @(negedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      if (idx == CSR_RING_BASE) ring_base = val;
      else max_packet = val[10:0];
   endtask

   // Stimulus: directed corners, then random phases across settings
   initial begin
      req_type r;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      r = make_req(OP_SETUP, 16'hFFFF, 32'h0);
      r.request_type = 8'hFF; r.request_code = 8'hFF; r.setup_value = 16'hFFFF;
      r.setup_index = 16'hFFFF; r.transfer_type = 2'd3;
      pending_reqs.push_back(r);
      r = '0;
      pending_reqs.push_back(r);
      pending_reqs.push_back(make_req(OP_DATA, 16'd0, 32'h1000));
      pending_reqs.push_back(make_req(OP_DATA, 16'd1, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(OP_DATA, 16'd2048, 32'hFFFF_FF00));
      pending_reqs.push_back(make_req(OP_DATA, 16'd2049, 32'h0));
      pending_reqs.push_back(make_req(OP_DATA, 16'hFFFF, 32'h0));
      r = make_req(OP_STATUS, 16'd0, 32'h0); r.direction = 1'b0; pending_reqs.push_back(r);
      r = make_req(OP_STATUS, 16'd0, 32'h0); r.direction = 1'b1; pending_reqs.push_back(r);
      r = make_req(OP_EVENT, 16'd0, 32'hFFFF_FFFF); r.want_interrupt = 1'b1;
      pending_reqs.push_back(r);
      r = make_req(OP_EVENT, 16'd0, 32'h0); r.want_interrupt = 1'b0;
      pending_reqs.push_back(r);
      pending_reqs.push_back(make_req(OP_PAGED, 16'd0, 32'h10));
      pending_reqs.push_back(make_req(OP_PAGED, 16'h0400, 32'hFFFF_FF00));
      pending_reqs.push_back(make_req(OP_PAGED, 16'hFFFF, 32'h0000_0FFF));
      pending_reqs.push_back(make_req(OP_PAGED, 16'd4096, 32'h0000_2000));
      pending_reqs.push_back(make_req(3'd5, 16'd100, 32'h0));
      pending_reqs.push_back(make_req(3'd6, 16'd100, 32'h0));
      pending_reqs.push_back(make_req(3'd7, 16'd100, 32'h0));
      wait_drained();

      write_csr(CSR_RING_BASE, 32'hFFFF_FFFF);
      write_csr(CSR_MPS, 32'd1);
      pending_reqs.push_back(make_req(OP_DATA, 16'd32, 32'h0));
      pending_reqs.push_back(make_req(OP_DATA, 16'd33, 32'h0));
      repeat (20) pending_reqs.push_back(random_req());
      wait_drained();

      write_csr(CSR_RING_BASE, $urandom);
      write_csr(CSR_MPS, 32'd1024);
      repeat (35) pending_reqs.push_back(random_req());
      wait_drained();

      write_csr(CSR_MPS, 32'd0);
      repeat (10) pending_reqs.push_back(random_req());
      wait_drained();

      write_csr(CSR_RING_BASE, 32'h0);
      write_csr(CSR_MPS, 32'h7FF);
      repeat (10) pending_reqs.push_back(random_req());
      wait_drained();

      write_csr(CSR_RING_BASE, $urandom);
      write_csr(CSR_MPS, $urandom_range(512, 8));
      repeat (15) pending_reqs.push_back(random_req());
      wait_drained();

      if (errors == 0 && expected_trbs.size() == 0)
         $display("transfer_ring_trb_producer_test: done, clean");
      else
         $display("transfer_ring_trb_producer_test: done, errors");
      $finish;
   end
endmodule
